// ----- rtl/core/fes_pkg.sv -----
// ----------------------------------------------------------------------------
// fes_pkg
// Shared types and constants of the flight event sequencer: phase and
// command codes, configuration register indexes, the configuration bundle
// and the classified sample beat that travels from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package fes_pkg;

  // Sequencer phases, encoded as reported on flight_state
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ARMED     = 3'd1,
    PH_POWERED   = 3'd2,
    PH_COAST     = 3'd3,
    PH_EVENT1    = 3'd4,
    PH_EVENT2    = 3'd5,
    PH_TOUCHDOWN = 3'd6
  } phase_e;

  // Uplink command after decode; the unused code behaves like none
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ARM   = 2'd1,
    CMD_RESET = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BURNOUT      = 3'd0,
    REG_EVENT1_TMO   = 3'd1,
    REG_EVENT2_TMO   = 3'd2,
    REG_EVENT2_ALT   = 3'd3,
    REG_LIFT_ACCEL   = 3'd4,
    REG_LIFT_HOLD    = 3'd5,
    REG_GROUND_BAND  = 3'd6,
    REG_TOUCH_HOLD   = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Reset values of the configuration registers
  localparam logic [15:0] BurnoutRst    = 16'd5000;
  localparam logic [15:0] Event1TmoRst  = 16'd10000;
  localparam logic [15:0] Event2TmoRst  = 16'd20000;
  localparam logic [23:0] Event2AltRst  = 24'd0;
  localparam logic [16:0] LiftAccelRst  = 17'd0;
  localparam logic [15:0] LiftHoldRst   = 16'd100;
  localparam logic [22:0] GroundBandRst = 23'd320;
  localparam logic [15:0] TouchHoldRst  = 16'd10000;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration bundle (signed fields are two's complement)
  typedef struct packed {
    logic [15:0] burnout_ms;
    logic [15:0] event1_timeout_ms;
    logic [15:0] event2_timeout_ms;
    logic [23:0] event2_altitude;
    logic [16:0] liftoff_accel_limit;
    logic [15:0] liftoff_hold_ms;
    logic [22:0] ground_band;
    logic [15:0] touchdown_hold_ms;
  } cfg_t;

  // Classified sample beat
  typedef struct packed {
    logic [31:0] now_ms;
    logic [23:0] altitude;
    logic        accel_low;  // accel below liftoff limit
    logic        alt_low;    // altitude at or below event 2 altitude
    cmd_e        cmd;
  } item_t;

endpackage : fes_pkg

`default_nettype wire

// ----- rtl/core/fes_front.sv -----
// ----------------------------------------------------------------------------
// fes_front
// Input side: takes sample beats, decodes the uplink command and does the
// state-free comparisons against configuration, then pushes the classified
// beat into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fes_front (
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [31:0]   now_ms_i,
  input  wire logic [16:0]   accel_y_i,
  input  wire logic [23:0]   altitude_i,
  input  wire logic [1:0]    command_i,
  input  fes_pkg::cfg_t      cfg_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output fes_pkg::item_t     q_item_o
);
  import fes_pkg::*;

  cmd_e cmd;

  // Command decode; code three is ignored
  always_comb begin
    unique case (command_i)
      2'd1:    cmd = CMD_ARM;
      2'd2:    cmd = CMD_RESET;
      default: cmd = CMD_NONE;
    endcase
  end

  // Handshake: stall only while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classified beat
  always_comb begin
    q_item_o.now_ms    = now_ms_i;
    q_item_o.altitude  = altitude_i;
    q_item_o.accel_low = $signed(accel_y_i) < $signed(cfg_i.liftoff_accel_limit);
    q_item_o.alt_low   = $signed(altitude_i) <= $signed(cfg_i.event2_altitude);
    q_item_o.cmd       = cmd;
  end

endmodule : fes_front

`default_nettype wire

// ----- rtl/core/fes_queue.sv -----
// ----------------------------------------------------------------------------
// fes_queue
// Short FIFO of classified beats between front and back. Push and pop may
// happen in the same cycle, so one beat per clock flows while the back pops.
// ----------------------------------------------------------------------------
`default_nettype none

module fes_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  fes_pkg::item_t   item_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output fes_pkg::item_t   head_o,
  output logic             head_valid_o
);
  import fes_pkg::*;

  item_t                 entries_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue fill count beyond depth");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");
`endif

endmodule : fes_queue

`default_nettype wire

// ----- rtl/core/fes_back.sv -----
// ----------------------------------------------------------------------------
// fes_back
// Sequencer: pops one classified beat whenever the result slot is free,
// applies the command, steps the phase machine with its hold qualifiers
// and timers, and presents phase and line levels as the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fes_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  fes_pkg::cfg_t    cfg_i,
  input  fes_pkg::item_t   head_i,
  input  wire logic        head_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       flight_state_o,
  output logic             arm_enable_o,
  output logic             fire_drogue_o,
  output logic             fire_main_o,
  output logic             logging_on_o
);
  import fes_pkg::*;

  // Sequencer state
  phase_e       phase_q, phase_d;
  logic         entry_q, entry_d;
  logic [31:0]  liftoff_time_q, liftoff_time_d;
  logic [31:0]  burn_start_q, burn_start_d;
  logic         lift_act_q, lift_act_d;
  logic [31:0]  lift_start_q, lift_start_d;
  logic         land_act_q, land_act_d;
  logic [31:0]  land_start_q, land_start_d;
  logic [23:0]  ground_q, ground_d;
  logic         arm_q, arm_d;
  logic         drogue_q, drogue_d;
  logic         main_q, main_d;
  logic         log_q, log_d;
  logic         out_valid_q, out_valid_d;

  // Conditions of the head beat
  phase_e       ph_eff;
  logic         entry_eff;
  logic         is_reset;
  logic [31:0]  lift_elapsed, land_elapsed, burn_elapsed, fly_elapsed;
  logic         lift_seen, touch_seen, burn_done, e1_due, e2_due;
  logic [24:0]  alt_diff, alt_mag;
  logic         near_ground;

  // Pop when the result slot is empty or being taken
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  // Command applies first, then qualifiers and timers
  always_comb begin
    is_reset     = (head_i.cmd == CMD_RESET);
    ph_eff       = (head_i.cmd == CMD_ARM) ? PH_ARMED : phase_q;
    entry_eff    = (head_i.cmd == CMD_ARM) || entry_q;
    lift_elapsed = head_i.now_ms - lift_start_q;
    land_elapsed = head_i.now_ms - land_start_q;
    burn_elapsed = head_i.now_ms - burn_start_q;
    fly_elapsed  = head_i.now_ms - liftoff_time_q;
    // a hold started by this beat has zero elapsed time
    lift_seen    = head_i.accel_low && lift_act_q &&
                   (lift_elapsed > {16'd0, cfg_i.liftoff_hold_ms});
    // burn_start is taken from this beat on entry, elapsed is then zero
    burn_done    = !entry_eff && (burn_elapsed > {16'd0, cfg_i.burnout_ms});
    e1_due       = fly_elapsed > {16'd0, cfg_i.event1_timeout_ms};
    e2_due       = head_i.alt_low || (fly_elapsed > {16'd0, cfg_i.event2_timeout_ms});
    alt_diff     = {head_i.altitude[23], head_i.altitude} - {ground_q[23], ground_q};
    alt_mag      = alt_diff[24] ? (25'd0 - alt_diff) : alt_diff;
    near_ground  = alt_mag < {2'd0, cfg_i.ground_band};
    touch_seen   = near_ground && land_act_q &&
                   (land_elapsed > {16'd0, cfg_i.touchdown_hold_ms});
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    entry_d = entry_q;
    if (pop_o) begin
      if (is_reset) begin
        phase_d = PH_IDLE;
        entry_d = 1'b1;
      end else begin
        phase_d = ph_eff;
        entry_d = entry_eff;
        unique case (ph_eff)
          PH_IDLE, PH_ARMED: begin
            entry_d = 1'b0;
            if (lift_seen) begin
              phase_d = PH_POWERED;
              entry_d = 1'b1;
            end
          end
          PH_POWERED: begin
            entry_d = 1'b0;
            if (burn_done) begin
              phase_d = PH_COAST;
              entry_d = 1'b1;
            end
          end
          PH_COAST: begin
            if (e1_due) begin
              phase_d = PH_EVENT1;
              entry_d = 1'b1;
            end
          end
          PH_EVENT1: begin
            entry_d = 1'b0;
            if (e2_due) begin
              phase_d = PH_EVENT2;
              entry_d = 1'b1;
            end
          end
          PH_EVENT2: begin
            entry_d = 1'b0;
            if (touch_seen) begin
              phase_d = PH_TOUCHDOWN;
              entry_d = 1'b1;
            end
          end
          PH_TOUCHDOWN: begin
            entry_d = entry_eff;
          end
          default: begin
            phase_d = PH_IDLE;
            entry_d = 1'b1;
          end
        endcase
      end
    end
  end

  // Entry actions, holds, timestamps and lines
  always_comb begin
    liftoff_time_d = liftoff_time_q;
    burn_start_d   = burn_start_q;
    lift_act_d     = lift_act_q;
    lift_start_d   = lift_start_q;
    land_act_d     = land_act_q;
    land_start_d   = land_start_q;
    ground_d       = ground_q;
    arm_d          = arm_q;
    drogue_d       = drogue_q;
    main_d         = main_q;
    log_d          = log_q;
    if (pop_o && (is_reset || !(ph_eff inside {PH_IDLE, PH_ARMED, PH_POWERED,
        PH_COAST, PH_EVENT1, PH_EVENT2, PH_TOUCHDOWN}))) begin
      liftoff_time_d = '0;
      burn_start_d   = '0;
      lift_act_d     = 1'b0;
      lift_start_d   = '0;
      land_act_d     = 1'b0;
      land_start_d   = '0;
      ground_d       = '0;
      arm_d          = 1'b0;
      drogue_d       = 1'b0;
      main_d         = 1'b0;
      log_d          = 1'b0;
    end else if (pop_o) begin
      unique case (ph_eff)
        PH_IDLE, PH_ARMED: begin
          if (entry_eff) begin
            // idle drops the lines and captures ground, armed raises them
            arm_d = (ph_eff == PH_ARMED);
            log_d = (ph_eff == PH_ARMED);
            if (ph_eff == PH_IDLE) begin
              ground_d = head_i.altitude;
            end
          end
          // liftoff hold restarts whenever the condition drops
          if (head_i.accel_low) begin
            if (!lift_act_q) begin
              lift_act_d   = 1'b1;
              lift_start_d = head_i.now_ms;
            end
          end else begin
            lift_act_d = 1'b0;
          end
          if (lift_seen) begin
            liftoff_time_d = head_i.now_ms;
            if (ph_eff == PH_IDLE) begin
              arm_d = 1'b1;
              log_d = 1'b1;
            end
          end
        end
        PH_POWERED: begin
          if (entry_eff) begin
            burn_start_d = head_i.now_ms;
          end
        end
        PH_COAST: begin
          // timer only
        end
        PH_EVENT1: begin
          if (entry_eff) begin
            drogue_d = 1'b1;
          end
        end
        PH_EVENT2: begin
          if (entry_eff) begin
            main_d = 1'b1;
          end
          if (near_ground) begin
            if (!land_act_q) begin
              land_act_d   = 1'b1;
              land_start_d = head_i.now_ms;
            end
          end else begin
            land_act_d = 1'b0;
          end
        end
        PH_TOUCHDOWN: begin
          arm_d = 1'b0;
          log_d = 1'b0;
        end
        default: begin
          // unreachable code, handled by the clear branch above
        end
      endcase
    end
  end

  // Result slot
  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      entry_q        <= 1'b1;
      liftoff_time_q <= '0;
      burn_start_q   <= '0;
      lift_act_q     <= 1'b0;
      lift_start_q   <= '0;
      land_act_q     <= 1'b0;
      land_start_q   <= '0;
      ground_q       <= '0;
      arm_q          <= 1'b0;
      drogue_q       <= 1'b0;
      main_q         <= 1'b0;
      log_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      entry_q        <= entry_d;
      liftoff_time_q <= liftoff_time_d;
      burn_start_q   <= burn_start_d;
      lift_act_q     <= lift_act_d;
      lift_start_q   <= lift_start_d;
      land_act_q     <= land_act_d;
      land_start_q   <= land_start_d;
      ground_q       <= ground_d;
      arm_q          <= arm_d;
      drogue_q       <= drogue_d;
      main_q         <= main_d;
      log_q          <= log_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // State only moves on a pop, so it doubles as the held result beat
  assign out_valid_o    = out_valid_q;
  assign flight_state_o = phase_q;
  assign arm_enable_o   = arm_q;
  assign fire_drogue_o  = drogue_q;
  assign fire_main_o    = main_q;
  assign logging_on_o   = log_q;

`ifndef NO_ASSERTIONS
  a_main_after_drogue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_q |-> drogue_q)
    else $error("main fired without drogue");

  a_drogue_latched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(drogue_q) |-> $past(pop_o && head_i.cmd == CMD_RESET))
    else $error("drogue line dropped without reset command");

  a_state_held_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(phase_q) && $stable(main_q))
    else $error("result changed while stalled");
`endif

endmodule : fes_back

`default_nettype wire

// ----- rtl/core/flight_event_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// flight_event_sequencer_unit
// Recovery sequencer for one sensor sample per beat.
//
// Input channel (in_valid_i / in_stall_o): one sample beat of time, vertical
// acceleration, altitude and uplink command. Output channel (out_valid_o /
// out_stall_i): one result beat per sample with the phase and the arm,
// drogue, main and logging lines after that sample.
// A result is registered in the back once its sample has left the queue.
// Throughput: one sample per cycle while the receiver does not stall; the
// front classifies and pushes into a two-beat queue, the back steps the
// phase machine once per popped beat. When the receiver stalls the result
// holds, the back stops popping, and the input stalls once the queue fills.
// Reset puts the machine in idle with entry pending, all lines low, and the
// configuration registers at their defaults. The configuration port is always
// ready. Write it only while no samples are in flight; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module flight_event_sequencer_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // sample channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [31:0]                    now_ms_i,
  input  wire logic [16:0]                    accel_y_i,
  input  wire logic [23:0]                    altitude_i,
  input  wire logic [1:0]                     command_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [2:0]                          flight_state_o,
  output logic                                arm_enable_o,
  output logic                                fire_drogue_o,
  output logic                                fire_main_o,
  output logic                                logging_on_o,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fes_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [fes_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import fes_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   q_push, q_full, q_pop, q_head_valid;
  item_t  q_item, q_head;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_BURNOUT:     cfg_d.burnout_ms          = cfg_wdata_i[15:0];
        REG_EVENT1_TMO:  cfg_d.event1_timeout_ms   = cfg_wdata_i[15:0];
        REG_EVENT2_TMO:  cfg_d.event2_timeout_ms   = cfg_wdata_i[15:0];
        REG_EVENT2_ALT:  cfg_d.event2_altitude     = cfg_wdata_i[23:0];
        REG_LIFT_ACCEL:  cfg_d.liftoff_accel_limit = cfg_wdata_i[16:0];
        REG_LIFT_HOLD:   cfg_d.liftoff_hold_ms     = cfg_wdata_i[15:0];
        REG_GROUND_BAND: cfg_d.ground_band         = cfg_wdata_i[22:0];
        REG_TOUCH_HOLD:  cfg_d.touchdown_hold_ms   = cfg_wdata_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.burnout_ms          <= BurnoutRst;
      cfg_q.event1_timeout_ms   <= Event1TmoRst;
      cfg_q.event2_timeout_ms   <= Event2TmoRst;
      cfg_q.event2_altitude     <= Event2AltRst;
      cfg_q.liftoff_accel_limit <= LiftAccelRst;
      cfg_q.liftoff_hold_ms     <= LiftHoldRst;
      cfg_q.ground_band         <= GroundBandRst;
      cfg_q.touchdown_hold_ms   <= TouchHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify
  fes_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .now_ms_i   (now_ms_i),
    .accel_y_i  (accel_y_i),
    .altitude_i (altitude_i),
    .command_i  (command_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  // Queue between front and back
  fes_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .item_i       (q_item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .head_valid_o (q_head_valid)
  );

  // Back: phase machine and result
  fes_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (q_head),
    .head_valid_i   (q_head_valid),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .flight_state_o (flight_state_o),
    .arm_enable_o   (arm_enable_o),
    .fire_drogue_o  (fire_drogue_o),
    .fire_main_o    (fire_main_o),
    .logging_on_o   (logging_on_o)
  );

endmodule : flight_event_sequencer_unit

`default_nettype wire

// ----- sim/tb_flight_event_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_flight_event_sequencer_unit
// Self-checking bench for the flight event sequencer. A directed flight walks
// every phase, command and hold restart. Flights steered by the predicted
// phase then run under default, fast, extreme and random register settings.
// Each result beat is checked field by field against the in-bench predictor.
// ----------------------------------------------------------------------------
module tb_flight_event_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fes_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  CMD_SPARE  = 2'd3;  // unused code, acts like none

  typedef struct packed {
    phase_e state;
    logic   arm;
    logic   drogue;
    logic   main_line;
    logic   log_en;
  } seq_out_t;

  // DUT signals
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [31:0]         now_ms;
  logic [16:0]         accel_y;
  logic [23:0]         altitude;
  logic [1:0]          command;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          flight_state;
  logic                arm_en;
  logic                fire_drg;
  logic                fire_mn;
  logic                log_on;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  // predictor registers
  logic [15:0]        burnout_lim;
  logic [15:0]        e1_tmo;
  logic [15:0]        e2_tmo;
  logic signed [23:0] e2_alt;
  logic signed [16:0] lift_accel;
  logic [15:0]        lift_hold;
  logic [22:0]        gnd_band;
  logic [15:0]        touch_hold;

  // predictor state
  phase_e             cur_phase;
  bit                 entry_due;
  logic [31:0]        t_liftoff;
  logic [31:0]        t_burn;
  bit                 lift_active;
  logic [31:0]        t_lift_hold;
  bit                 land_active;
  logic [31:0]        t_land_hold;
  logic signed [23:0] ground_alt;
  bit                 line_arm;
  bit                 line_drogue;
  bit                 line_main;
  bit                 line_log;

  seq_out_t    expected_q[$];
  int          errors = 0;
  int unsigned cycles = 0;
  int          rx_wait = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  logic [31:0] t_cursor = '0;

  flight_event_sequencer_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .now_ms_i       (now_ms),
    .accel_y_i      (accel_y),
    .altitude_i     (altitude),
    .command_i      (command),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .flight_state_o (flight_state),
    .arm_enable_o   (arm_en),
    .fire_drogue_o  (fire_drg),
    .fire_main_o    (fire_mn),
    .logging_on_o   (log_on),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void clear_sequencer();
    cur_phase   = PH_IDLE;
    entry_due   = 1'b1;
    t_liftoff   = '0;
    t_burn      = '0;
    lift_active = 1'b0;
    t_lift_hold = '0;
    land_active = 1'b0;
    t_land_hold = '0;
    ground_alt  = '0;
    line_arm    = 1'b0;
    line_drogue = 1'b0;
    line_main   = 1'b0;
    line_log    = 1'b0;
  endfunction

  // liftoff hold: restarts whenever accel rises to the limit
  function automatic bit liftoff_held(input logic [31:0] now,
                                      input logic signed [16:0] acc);
    if (acc < lift_accel) begin
      if (!lift_active) begin
        lift_active = 1'b1;
        t_lift_hold = now;
      end
      return (now - t_lift_hold) > lift_hold;
    end
    lift_active = 1'b0;
    return 1'b0;
  endfunction

  // one sample through the sequencer; returns the lines after it
  function automatic seq_out_t advance_sequencer(input logic [31:0] now,
                                                 input logic signed [16:0] acc,
                                                 input logic signed [23:0] alt,
                                                 input logic [1:0] cmd);
    seq_out_t res;
    int       alt_gap;
    bit       run;
    run = 1'b1;
    // command acts before the phase update
    if (cmd == CMD_RESET) begin
      clear_sequencer();
      run = 1'b0;
    end else if (cmd == CMD_ARM) begin
      cur_phase = PH_ARMED;
      entry_due = 1'b1;
    end
    if (run) begin
      case (cur_phase)
        PH_IDLE: begin
          if (entry_due) begin
            line_arm   = 1'b0;
            line_log   = 1'b0;
            ground_alt = alt;
            entry_due  = 1'b0;
          end
          if (liftoff_held(now, acc)) begin
            cur_phase = PH_POWERED;
            entry_due = 1'b1;
            t_liftoff = now;
            line_arm  = 1'b1;
            line_log  = 1'b1;
          end
        end
        PH_ARMED: begin
          if (entry_due) begin
            line_arm  = 1'b1;
            line_log  = 1'b1;
            entry_due = 1'b0;
          end
          if (liftoff_held(now, acc)) begin
            cur_phase = PH_POWERED;
            entry_due = 1'b1;
            t_liftoff = now;
          end
        end
        PH_POWERED: begin
          if (entry_due) begin
            t_burn    = now;
            entry_due = 1'b0;
          end
          if ((now - t_burn) > burnout_lim) begin
            cur_phase = PH_COAST;
            entry_due = 1'b1;
          end
        end
        PH_COAST: begin
          if ((now - t_liftoff) > e1_tmo) begin
            cur_phase = PH_EVENT1;
            entry_due = 1'b1;
          end
        end
        PH_EVENT1: begin
          if (entry_due) begin
            line_drogue = 1'b1;
            entry_due   = 1'b0;
          end
          if (alt <= e2_alt || (now - t_liftoff) > e2_tmo) begin
            cur_phase = PH_EVENT2;
            entry_due = 1'b1;
          end
        end
        PH_EVENT2: begin
          if (entry_due) begin
            line_main = 1'b1;
            entry_due = 1'b0;
          end
          // touchdown hold: altitude inside the ground band
          alt_gap = alt - ground_alt;
          if (alt_gap < 0) alt_gap = -alt_gap;
          if (alt_gap < int'(gnd_band)) begin
            if (!land_active) begin
              land_active = 1'b1;
              t_land_hold = now;
            end
            if ((now - t_land_hold) > touch_hold) begin
              cur_phase = PH_TOUCHDOWN;
              entry_due = 1'b1;
            end
          end else begin
            land_active = 1'b0;
          end
        end
        PH_TOUCHDOWN: begin
          line_arm = 1'b0;
          line_log = 1'b0;
        end
        default: clear_sequencer();
      endcase
    end
    res.state     = cur_phase;
    res.arm       = line_arm;
    res.drogue    = line_drogue;
    res.main_line = line_main;
    res.log_en    = line_log;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(input string msg);
    errors++;
    if (errors <= 60) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  // register writes, accepted samples and result beats, all at the rising edge
  always @(posedge clk) begin
    seq_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BURNOUT:     burnout_lim = cfg_wdata[15:0];
          REG_EVENT1_TMO:  e1_tmo      = cfg_wdata[15:0];
          REG_EVENT2_TMO:  e2_tmo      = cfg_wdata[15:0];
          REG_EVENT2_ALT:  e2_alt      = cfg_wdata[23:0];
          REG_LIFT_ACCEL:  lift_accel  = cfg_wdata[16:0];
          REG_LIFT_HOLD:   lift_hold   = cfg_wdata[15:0];
          REG_GROUND_BAND: gnd_band    = cfg_wdata[22:0];
          REG_TOUCH_HOLD:  touch_hold  = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(advance_sequencer(now_ms, accel_y, altitude, command));
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
        rx_wait = draw_wait(rx_calm);
        if (expected_q.size() == 0) begin
          report("result beat with nothing pending");
        end else begin
          want = expected_q.pop_front();
          if (flight_state !== want.state)
            report($sformatf("flight_state %0d, want %0d", flight_state, want.state));
          if (arm_en !== want.arm)
            report($sformatf("arm_enable %b, want %b", arm_en, want.arm));
          if (fire_drg !== want.drogue)
            report($sformatf("fire_drogue %b, want %b", fire_drg, want.drogue));
          if (fire_mn !== want.main_line)
            report($sformatf("fire_main %b, want %b", fire_mn, want.main_line));
          if (log_on !== want.log_en)
            report($sformatf("logging_on %b, want %b", log_on, want.log_en));
        end
      end
    end
  end

  // receiver backpressure, counted down per cycle
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall = 1'b1;
      rx_wait--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_sample(input logic [31:0] now, input int acc, input int alt,
                             input logic [1:0] cmd);
    int gap;
    gap = draw_wait(tx_calm);
    if ($urandom_range(0, 47) == 0) tx_calm = !tx_calm;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    now_ms   = now;
    accel_y  = acc[16:0];
    altitude = alt[23:0];
    command  = cmd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input int value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[23:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off until every pending result is back, then let the pipe go quiet
  task automatic settle();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(input int burn, input int tmo1, input int tmo2,
                               input int alt2, input int acc_lim, input int hold_lift,
                               input int band, input int hold_land);
    settle();
    cfg_write(REG_BURNOUT, burn);
    cfg_write(REG_EVENT1_TMO, tmo1);
    cfg_write(REG_EVENT2_TMO, tmo2);
    cfg_write(REG_EVENT2_ALT, alt2);
    cfg_write(REG_LIFT_ACCEL, acc_lim);
    cfg_write(REG_LIFT_HOLD, hold_lift);
    cfg_write(REG_GROUND_BAND, band);
    cfg_write(REG_TOUCH_HOLD, hold_land);
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_alt(input int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic int alt_above();
    int lo;
    lo = e2_alt + 1;
    return clamp_alt(pick(lo, lo + 60000));
  endfunction

  function automatic int near_ground(input bit in_band);
    int b;
    b = int'(gnd_band);
    if (in_band && b > 0) return clamp_alt(ground_alt + pick(1 - b, b - 1));
    if ($urandom_range(0, 1)) return clamp_alt(ground_alt + b + pick(0, 4000));
    return clamp_alt(ground_alt - b - pick(0, 4000));
  endfunction

  // flights steered by the predicted phase, with commands and some noise
  task automatic fly(input int count);
    int          acc;
    int          alt;
    int          pace;
    int          r;
    logic [31:0] now;
    logic [1:0]  cmd;
    pace = burnout_lim;
    if (e1_tmo > pace) pace = e1_tmo;
    if (e2_tmo > pace) pace = e2_tmo;
    if (lift_hold > pace) pace = lift_hold;
    if (touch_hold > pace) pace = touch_hold;
    pace = pace / 6 + 2;
    for (int i = 0; i < count; i++) begin
      t_cursor += $urandom_range(0, pace);
      now = t_cursor;
      acc = pick(-65536, 65535);
      case (cur_phase)
        PH_IDLE, PH_ARMED: begin
          if ($urandom_range(0, 9) != 0 && lift_accel > -65536)
            acc = pick(-65536, lift_accel - 1);
          alt = near_ground(1'b1);
        end
        PH_POWERED, PH_COAST: alt = alt_above();
        PH_EVENT1: alt = ($urandom_range(0, 3) == 0) ? pick(-8388608, e2_alt) : alt_above();
        PH_EVENT2: alt = near_ground($urandom_range(0, 7) != 0);
        default:   alt = near_ground(1'b1);
      endcase
      r = $urandom_range(0, 99);
      cmd = CMD_NONE;
      if (r < 3) cmd = CMD_ARM;
      else if (r < 5) cmd = CMD_RESET;
      else if (r < 6) cmd = CMD_SPARE;
      else if (cur_phase == PH_TOUCHDOWN && r < 30) cmd = (r < 18) ? CMD_RESET : CMD_ARM;
      // noise: raw fields and time jumps
      if (r >= 90) begin
        now = $urandom();
        acc = $urandom();
        alt = $urandom();
        if (r >= 97) t_cursor = now;
      end
      send_sample(now, acc, alt, cmd);
    end
  endtask

  // ---------------------------------------------------------------- tests
  // default registers: every phase, hold restarts, all commands, field extremes
  task automatic test_directed_flight();
    send_sample(32'd0, 65535, 0, CMD_NONE);             // idle entry, ground 0
    send_sample(32'd10, -65536, 8388607, CMD_NONE);     // liftoff hold starts
    send_sample(32'd111, -1, 100, CMD_NONE);            // liftoff from idle
    send_sample(32'd200, 0, 100, CMD_ARM);              // arm mid-ascent, hold drops
    send_sample(32'd300, -300, 50, CMD_NONE);
    send_sample(32'd400, -300, 50, CMD_NONE);           // exactly the hold time
    send_sample(32'd401, -300, 50, CMD_NONE);           // liftoff from armed
    send_sample(32'd5000, 0, 4000, CMD_NONE);           // burn start
    send_sample(32'd10001, 0, 4000, CMD_NONE);          // burnout
    send_sample(32'd10401, 0, 4000, CMD_NONE);          // event 1 timeout edge
    send_sample(32'd10402, 0, 4000, CMD_SPARE);         // code three ignored
    send_sample(32'd10403, 0, 4000, CMD_NONE);          // drogue fires
    send_sample(32'd20402, 0, 4000, CMD_NONE);          // event 2 by timeout
    send_sample(32'd20500, 0, 8388607, CMD_NONE);       // main fires, out of band
    send_sample(32'd20600, 0, -319, CMD_NONE);          // touchdown hold starts
    send_sample(32'd25000, 0, 320, CMD_NONE);           // band edge, hold drops
    send_sample(32'd25001, 0, 0, CMD_NONE);
    send_sample(32'd35002, 0, 319, CMD_NONE);           // touchdown
    send_sample(32'd35003, 0, 0, CMD_NONE);             // arm and logging off
    send_sample(32'd35004, 0, 0, CMD_ARM);              // fire lines stay latched
    send_sample(32'd35005, -65536, -8388608, CMD_RESET);
    send_sample(32'hFFFF_FFF0, -65536, -8388608, CMD_NONE);
    send_sample(32'h0000_0060, -65536, 0, CMD_NONE);    // liftoff across time wrap
    send_sample(32'hFFFF_FFFF, 65535, 8388607, CMD_RESET);
  endtask

  task automatic test_default_flights();
    t_cursor = $urandom();
    fly(200);
  endtask

  task automatic test_fast_flights();
    load_settings(40, 80, 160, 0, 0, 10, 320, 60);
    t_cursor = 32'hFFFF_F000;
    fly(300);
  endtask

  task automatic test_extreme_settings();
    load_settings(0, 0, 0, -8388608, -65536, 0, 0, 0);
    fly(100);
    load_settings(65535, 65535, 65535, 8388607, 65535, 65535, 8388607, 65535);
    fly(200);
    load_settings(0, 0, 0, -8388608, 65535, 0, 8388607, 0);
    fly(150);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      load_settings($urandom_range(0, 400), $urandom_range(0, 600), $urandom_range(0, 900),
                    pick(-3000, 3000), pick(-3000, 3000), $urandom_range(0, 60),
                    $urandom_range(0, 2000), $urandom_range(0, 300));
      fly(120);
    end
    load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), pick(-8388608, 8388607), pick(-65536, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 8388607),
                  $urandom_range(0, 65535));
    fly(100);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    now_ms    = '0;
    accel_y   = '0;
    altitude  = '0;
    command   = CMD_NONE;
    cfg_valid = 1'b0;
    cfg_index = REG_BURNOUT;
    cfg_wdata = '0;
    burnout_lim = BurnoutRst;
    e1_tmo      = Event1TmoRst;
    e2_tmo      = Event2TmoRst;
    e2_alt      = Event2AltRst;
    lift_accel  = LiftAccelRst;
    lift_hold   = LiftHoldRst;
    gnd_band    = GroundBandRst;
    touch_hold  = TouchHoldRst;
    clear_sequencer();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_flight();
    test_default_flights();
    test_fast_flights();
    test_extreme_settings();
    test_random_settings();

    settle();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
